// File: hdl/gaps_pkg.sv
// shared types, codes and neighbor tables of the grid path search block
package gaps_pkg;

  localparam int COORD_W    = 5;
  localparam int REQ_W      = 2;
  localparam int IDX_W      = 11;
  localparam int LEN_W      = 11;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [REQ_W-1:0] REQ_MAP_WR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  localparam logic [1:0] ST_FRESH = 2'd0;
  localparam logic [1:0] ST_OPEN  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  localparam logic [1:0] STEP_ZERO = 2'd0;
  localparam logic [1:0] STEP_POS  = 2'd1;
  localparam logic [1:0] STEP_NEG  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_blocked;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic               use_waypoint;
    logic [COORD_W-1:0] waypoint_x;
    logic [COORD_W-1:0] waypoint_y;
    logic [IDX_W-1:0]   step_index;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] closest_x;
    logic [COORD_W-1:0] closest_y;
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_y;
  } out_res_t;

  typedef struct packed {
    logic latch_req;
    logic map_wr;
    logic out_load;
    logic srch_init;
    logic leg_setup;
    logic clr_step;
    logic seed;
    logic scan_start;
    logic scan_issue;
    logic expand;
    logic exp_load;
    logic nb_issue;
    logic nb_check;
    logic nb_next;
    logic bt_init;
    logic bt_cnt_rd;
    logic bt_cnt_step;
    logic bt_wr_init;
    logic bt_wr;
    logic bt_wr_step;
    logic leg_ok;
    logic leg_fail;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic leg_trivial;
    logic leg_outside;
    logic clr_last;
    logic scan_last;
    logic any_open;
    logic goal_hit;
    logic nb_ok;
    logic nb_last;
    logic bt_at_start;
    logic bt_k_last;
    logic leg2_pend;
  } ctrl_sts_t;

  // neighbor order: long axis first, then the short axis, then the four diagonals
  function automatic logic [1:0] nb_dx(input logic long_y, input logic [2:0] idx);
    logic [1:0] d;
    case (idx)
      3'd0: d = long_y ? STEP_ZERO : STEP_NEG;
      3'd1: d = long_y ? STEP_ZERO : STEP_POS;
      3'd2: d = long_y ? STEP_NEG : STEP_ZERO;
      3'd3: d = long_y ? STEP_POS : STEP_ZERO;
      3'd4: d = STEP_NEG;
      3'd5: d = STEP_NEG;
      3'd6: d = STEP_POS;
      default: d = STEP_POS;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] nb_dy(input logic long_y, input logic [2:0] idx);
    logic [1:0] d;
    case (idx)
      3'd0: d = long_y ? STEP_NEG : STEP_ZERO;
      3'd1: d = long_y ? STEP_POS : STEP_ZERO;
      3'd2: d = long_y ? STEP_ZERO : STEP_NEG;
      3'd3: d = long_y ? STEP_ZERO : STEP_POS;
      3'd4: d = STEP_NEG;
      3'd5: d = STEP_POS;
      3'd6: d = STEP_POS;
      default: d = STEP_NEG;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/grid_astar_path_search_core.sv
// top level of the grid path search block: sequencer, datapath and result register
// map write or path read: result registered through the dispatch, read and result states, one request at a time
// search: per leg a clear pass over all 2**(clog2(W)+clog2(H)) cells (1024 by default),
//   then per expansion an open-set scan over w*h cells plus the eight neighbor checks,
//   then a walk back over the path cells, counted and then written; one leg or two
// rst_n is synchronous; map and path store hold no reset value, results reset to zero
module grid_astar_path_search_core #(
  parameter int MAX_GRID_W = 32,
  parameter int MAX_GRID_H = 32,
  parameter int MAX_PATH   = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gaps_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gaps_pkg::out_res_t               out_res,
  input  logic                             cfg_wr_en,
  input  logic [gaps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gaps_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

  gaps_pkg::ctrl_cmd_t cmd;
  gaps_pkg::ctrl_sts_t sts;
  gaps_pkg::out_res_t  res;
  gaps_pkg::out_res_t  out_res_r;
  logic                out_valid_r;

  gaps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_valid_r),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gaps_dpath #(
    .MAX_GRID_W (MAX_GRID_W),
    .MAX_GRID_H (MAX_GRID_H),
    .MAX_PATH   (MAX_PATH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .cmd         (cmd),
    .sts         (sts),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: hdl/gaps_ctrl.sv
// search sequencer state machine of the grid path search block
module gaps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_busy,
  input  gaps_pkg::ctrl_sts_t  sts,
  output gaps_pkg::ctrl_cmd_t  cmd,
  output logic                 in_stall
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_RDP   = 5'd2;
  localparam logic [4:0] S_RES   = 5'd3;
  localparam logic [4:0] S_LEG   = 5'd4;
  localparam logic [4:0] S_CLR   = 5'd5;
  localparam logic [4:0] S_SEED  = 5'd6;
  localparam logic [4:0] S_SCAN0 = 5'd7;
  localparam logic [4:0] S_SCAN  = 5'd8;
  localparam logic [4:0] S_SCANE = 5'd9;
  localparam logic [4:0] S_DEC   = 5'd10;
  localparam logic [4:0] S_EXP   = 5'd11;
  localparam logic [4:0] S_EXP2  = 5'd12;
  localparam logic [4:0] S_NBRD  = 5'd13;
  localparam logic [4:0] S_NBCK  = 5'd14;
  localparam logic [4:0] S_BTC   = 5'd15;
  localparam logic [4:0] S_BTC2  = 5'd16;
  localparam logic [4:0] S_BTW0  = 5'd17;
  localparam logic [4:0] S_BTW   = 5'd18;
  localparam logic [4:0] S_BTW2  = 5'd19;
  localparam logic [4:0] S_LOK   = 5'd20;
  localparam logic [4:0] S_FAIL  = 5'd21;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_stall = (state_r != S_IDLE) || out_busy;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_busy) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.req_type)
          gaps_pkg::REQ_MAP_WR: begin
            cmd.map_wr = 1'b1;
            state_nxt  = S_RDP;
          end
          gaps_pkg::REQ_SEARCH: begin
            cmd.srch_init = 1'b1;
            state_nxt     = S_LEG;
          end
          default: state_nxt = S_RDP;
        endcase
      end
      S_RDP: state_nxt = S_RES;
      S_RES: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_LEG: begin
        cmd.leg_setup = 1'b1;
        if (sts.leg_trivial) begin
          state_nxt = S_LOK;
        end else if (sts.leg_outside) begin
          state_nxt = S_FAIL;
        end else begin
          state_nxt = S_CLR;
        end
      end
      S_FAIL: begin
        cmd.leg_fail = 1'b1;
        state_nxt    = S_RDP;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_SCAN0;
      end
      S_SCAN0: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SCANE;
        end
      end
      S_SCANE: state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = sts.any_open ? S_EXP : S_FAIL;
      end
      S_EXP: begin
        cmd.expand = 1'b1;
        if (sts.goal_hit) begin
          cmd.bt_init = 1'b1;
          state_nxt   = S_BTC;
        end else begin
          state_nxt = S_EXP2;
        end
      end
      S_EXP2: begin
        cmd.exp_load = 1'b1;
        state_nxt    = S_NBRD;
      end
      S_NBRD: begin
        if (sts.nb_ok) begin
          cmd.nb_issue = 1'b1;
          state_nxt    = S_NBCK;
        end else if (sts.nb_last) begin
          state_nxt = S_SCAN0;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_NBCK: begin
        cmd.nb_check = 1'b1;
        if (sts.nb_last) begin
          state_nxt = S_SCAN0;
        end else begin
          cmd.nb_next = 1'b1;
          state_nxt   = S_NBRD;
        end
      end
      S_BTC: begin
        if (sts.bt_at_start) begin
          state_nxt = S_BTW0;
        end else begin
          cmd.bt_cnt_rd = 1'b1;
          state_nxt     = S_BTC2;
        end
      end
      S_BTC2: begin
        cmd.bt_cnt_step = 1'b1;
        state_nxt       = S_BTC;
      end
      S_BTW0: begin
        cmd.bt_wr_init = 1'b1;
        state_nxt      = S_BTW;
      end
      S_BTW: begin
        cmd.bt_wr = 1'b1;
        state_nxt = sts.bt_k_last ? S_LOK : S_BTW2;
      end
      S_BTW2: begin
        cmd.bt_wr_step = 1'b1;
        state_nxt      = S_BTW;
      end
      S_LOK: begin
        cmd.leg_ok = 1'b1;
        state_nxt  = sts.leg2_pend ? S_LEG : S_RDP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/gaps_dpath.sv
// map, working store, path store and search arithmetic of the grid path search block
module gaps_dpath #(
  parameter int MAX_GRID_W = 32,
  parameter int MAX_GRID_H = 32,
  parameter int MAX_PATH   = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [gaps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gaps_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  gaps_pkg::in_req_t                  in_req,
  input  gaps_pkg::ctrl_cmd_t                cmd,
  output gaps_pkg::ctrl_sts_t                sts,
  output gaps_pkg::out_res_t                 res
);

  localparam int XW    = $clog2(MAX_GRID_W);
  localparam int YW    = $clog2(MAX_GRID_H);
  localparam int AW    = XW + YW;
  localparam int CELLS = 2 ** AW;
  localparam int XYW   = (XW > YW) ? XW : YW;
  localparam int CW    = (XYW > gaps_pkg::COORD_W) ? XYW : gaps_pkg::COORD_W;
  localparam int DW    = CW + 1;
  localparam int EW    = CW + 2;
  localparam int CSTW  = $clog2(MAX_GRID_W * MAX_GRID_H) + 1;
  localparam int TW    = ((CSTW > EW) ? CSTW : EW) + 1;
  localparam int TAGW  = $clog2(9 * MAX_GRID_W * MAX_GRID_H) + 1;
  localparam int LW    = CW + XW + 2;
  localparam int PAW   = $clog2(MAX_PATH);
  localparam int PLW   = PAW + 1;
  localparam int NW    = AW + 1;
  localparam int QW    = ((PLW > NW) ? PLW : NW) + 1;
  localparam int RST_W = (MAX_GRID_W < 32) ? MAX_GRID_W : 32;
  localparam int RST_H = (MAX_GRID_H < 32) ? MAX_GRID_H : 32;
  localparam int CRD   = gaps_pkg::COORD_W;

  // memories
  logic            blk_mem  [CELLS];
  logic [1:0]      st_mem   [CELLS];
  logic [CSTW-1:0] cost_mem [CELLS];
  logic [AW-1:0]   pred_mem [CELLS];
  logic [TAGW-1:0] tag_mem  [CELLS];
  logic [AW-1:0]   path_mem [MAX_PATH];

  logic            blk_q;
  logic [1:0]      st_q;
  logic [CSTW-1:0] cost_q;
  logic [AW-1:0]   pred_q;
  logic [TAGW-1:0] tag_q;
  logic [AW-1:0]   path_q;

  // registers
  gaps_pkg::in_req_t req_r;
  logic [DW-1:0]   w_r, h_r;
  logic [CRD-1:0]  lsx_r, lsy_r, lgx_r, lgy_r;
  logic            from_r, leg2p_r, long_r;
  logic [LW-1:0]   goal_lin_r;
  logic [EW-1:0]   min_est_r;
  logic [CW-1:0]   clx_r, cly_r;
  logic [TAGW-1:0] tag_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [CW-1:0]   scx_r, scy_r;
  logic            pv_r;
  logic [CW-1:0]   pvx_r, pvy_r;
  logic            any_r;
  logic [CW-1:0]   bx_r, by_r;
  logic [TW-1:0]   bt_r;
  logic [EW-1:0]   be_r;
  logic [TAGW-1:0] bg_r;
  logic [CW-1:0]   cx_r, cy_r;
  logic            cblk_r;
  logic [CSTW-1:0] ncost_r;
  logic [2:0]      nb_r;
  logic [CW-1:0]   wkx_r, wky_r;
  logic [NW-1:0]   n_r, k_r;
  logic            res_found_r;
  logic [PLW-1:0]  res_len_r;
  logic [CRD-1:0]  res_cx_r, res_cy_r;

  // combinational
  logic [AW-1:0]   ra, wa;
  logic            blk_we, st_we, cost_we, pred_we, tag_we, path_we;
  logic [1:0]      st_wd;
  logic [CSTW-1:0] cost_wd;
  logic [AW-1:0]   pred_wd;
  logic [TAGW-1:0] tag_wd;
  logic [CW-1:0]   lsx_e, lsy_e, lgx_e, lgy_e;
  logic [1:0]      dxc, dyc;
  logic            x_ok, y_ok;
  logic [CW-1:0]   nx, ny;
  logic [EW-1:0]   ne, pe, se;
  logic [TW-1:0]   pt;
  logic            better;
  logic [LW-1:0]   b_lin;
  logic            live, nfresh, nopen;
  logic [QW-1:0]   pos, add_len;
  logic [DW-1:0]   cfg_dim;
  logic            step_ok;
  logic            map_in;

  function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [EW-1:0] est(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                        input logic [CW-1:0] gx, input logic [CW-1:0] gy);
    return EW'(adiff(x, gx)) + EW'(adiff(y, gy));
  endfunction

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return {y[YW-1:0], x[XW-1:0]};
  endfunction

  assign lsx_e = CW'(lsx_r);
  assign lsy_e = CW'(lsy_r);
  assign lgx_e = CW'(lgx_r);
  assign lgy_e = CW'(lgy_r);

  assign cfg_dim = (cfg_wr_data == '0) ? DW'(1) :
                   (32'(cfg_wr_data) > MAX_GRID_W) ? DW'(MAX_GRID_W) : DW'(cfg_wr_data);
  logic [DW-1:0] cfg_dim_h;
  assign cfg_dim_h = (cfg_wr_data == '0) ? DW'(1) :
                     (32'(cfg_wr_data) > MAX_GRID_H) ? DW'(MAX_GRID_H) : DW'(cfg_wr_data);

  // neighbor
  always_comb begin
    dxc  = gaps_pkg::nb_dx(long_r, nb_r);
    dyc  = gaps_pkg::nb_dy(long_r, nb_r);
    x_ok = 1'b1;
    y_ok = 1'b1;
    nx   = cx_r;
    ny   = cy_r;
    case (dxc)
      gaps_pkg::STEP_NEG: begin
        x_ok = (cx_r != '0);
        nx   = cx_r - 1'b1;
      end
      gaps_pkg::STEP_POS: begin
        x_ok = (DW'(cx_r) + DW'(1)) < w_r;
        nx   = cx_r + 1'b1;
      end
      default: ;
    endcase
    case (dyc)
      gaps_pkg::STEP_NEG: begin
        y_ok = (cy_r != '0);
        ny   = cy_r - 1'b1;
      end
      gaps_pkg::STEP_POS: begin
        y_ok = (DW'(cy_r) + DW'(1)) < h_r;
        ny   = cy_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign ne = est(nx, ny, lgx_e, lgy_e);
  assign se = est(lsx_e, lsy_e, lgx_e, lgy_e);

  // scan compare on the previous read
  assign pe     = est(pvx_r, pvy_r, lgx_e, lgy_e);
  assign pt     = TW'(pe) + TW'(cost_q);
  assign better = (st_q == gaps_pkg::ST_OPEN) &&
                  (!any_r || (pt < bt_r) || (pt == bt_r && pe < be_r) ||
                   (pt == bt_r && pe == be_r && tag_q < bg_r));

  assign b_lin  = LW'(by_r) * LW'(MAX_GRID_W) + LW'(bx_r);
  assign live   = cmd.nb_check && !blk_q;
  assign nfresh = (st_q == gaps_pkg::ST_FRESH);
  assign nopen  = (st_q == gaps_pkg::ST_OPEN);
  assign map_in = (32'(req_r.cell_x) < MAX_GRID_W) && (32'(req_r.cell_y) < MAX_GRID_H);

  assign pos     = QW'(res_len_r) + QW'(k_r) - QW'(1) - QW'(from_r);
  assign add_len = (n_r > NW'(from_r)) ? QW'(res_len_r) + QW'(n_r) - QW'(from_r)
                                       : QW'(res_len_r);

  // address and write muxes
  always_comb begin
    ra = addr(scx_r, scy_r);
    if (cmd.expand) begin
      ra = addr(bx_r, by_r);
    end else if (cmd.nb_issue) begin
      ra = addr(nx, ny);
    end else if (cmd.bt_cnt_rd || cmd.bt_wr) begin
      ra = addr(wkx_r, wky_r);
    end
  end

  always_comb begin
    wa      = clr_cnt_r;
    st_wd   = gaps_pkg::ST_FRESH;
    cost_wd = ncost_r;
    pred_wd = addr(cx_r, cy_r);
    tag_wd  = tag_r;
    if (cmd.seed) begin
      wa      = addr(lsx_e, lsy_e);
      st_wd   = gaps_pkg::ST_OPEN;
      cost_wd = '0;
      pred_wd = addr(lsx_e, lsy_e);
      tag_wd  = '0;
    end else if (cmd.expand) begin
      wa    = addr(bx_r, by_r);
      st_wd = gaps_pkg::ST_DONE;
    end else if (cmd.nb_check) begin
      wa    = addr(nx, ny);
      st_wd = gaps_pkg::ST_OPEN;
    end else if (cmd.map_wr) begin
      wa = addr(CW'(req_r.cell_x), CW'(req_r.cell_y));
    end
  end

  assign blk_we  = cmd.map_wr && map_in;
  assign st_we   = cmd.clr_step || cmd.seed || cmd.expand || (live && nfresh);
  assign cost_we = cmd.seed || (live && (nfresh || (nopen && ncost_r < cost_q)));
  assign pred_we = cost_we;
  assign tag_we  = cmd.seed || (live && (nfresh || nopen));
  assign path_we = cmd.bt_wr && (k_r > NW'(from_r)) && (pos < QW'(MAX_PATH));

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[wa] <= req_r.cell_blocked;
    end
    blk_q <= blk_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[wa] <= st_wd;
    end
    st_q <= st_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[wa] <= cost_wd;
    end
    cost_q <= cost_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[wa] <= pred_wd;
    end
    pred_q <= pred_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wa] <= tag_wd;
    end
    tag_q <= tag_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[pos[PAW-1:0]] <= addr(wkx_r, wky_r);
    end
    path_q <= path_mem[PAW'(req_r.step_index)];
  end

  // configuration and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= DW'(RST_W);
      h_r         <= DW'(RST_H);
      res_found_r <= 1'b0;
      res_len_r   <= '0;
      res_cx_r    <= '0;
      res_cy_r    <= '0;
      leg2p_r     <= 1'b0;
      from_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          gaps_pkg::CFG_MAP_WIDTH:  w_r <= cfg_dim;
          gaps_pkg::CFG_MAP_HEIGHT: h_r <= cfg_dim_h;
          default: ;
        endcase
      end
      if (cmd.srch_init) begin
        res_found_r <= 1'b0;
        res_len_r   <= '0;
        lsx_r       <= req_r.start_x;
        lsy_r       <= req_r.start_y;
        from_r      <= 1'b0;
        leg2p_r     <= req_r.use_waypoint;
        lgx_r       <= req_r.use_waypoint ? req_r.waypoint_x : req_r.goal_x;
        lgy_r       <= req_r.use_waypoint ? req_r.waypoint_y : req_r.goal_y;
      end
      if (cmd.leg_fail) begin
        res_found_r <= 1'b0;
        res_len_r   <= '0;
        res_cx_r    <= CRD'(clx_r);
        res_cy_r    <= CRD'(cly_r);
      end
      if (cmd.leg_ok) begin
        res_len_r <= (add_len > QW'(MAX_PATH)) ? PLW'(MAX_PATH) : PLW'(add_len);
        if (leg2p_r) begin
          leg2p_r <= 1'b0;
          from_r  <= 1'b1;
          lsx_r   <= req_r.waypoint_x;
          lsy_r   <= req_r.waypoint_y;
          lgx_r   <= req_r.goal_x;
          lgy_r   <= req_r.goal_y;
        end else begin
          res_found_r <= 1'b1;
          res_cx_r    <= req_r.goal_x;
          res_cy_r    <= req_r.goal_y;
        end
      end
    end
  end

  // search working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= in_req;
    end
    if (cmd.leg_setup) begin
      min_est_r  <= EW'(w_r) + EW'(h_r);
      clx_r      <= lsx_e;
      cly_r      <= lsy_e;
      long_r     <= adiff(lgy_e, lsy_e) > adiff(lgx_e, lsx_e);
      goal_lin_r <= LW'(lgy_r) * LW'(MAX_GRID_W) + LW'(lgx_r);
      clr_cnt_r  <= '0;
      n_r        <= '0;
    end
    if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
    if (cmd.seed) begin
      tag_r <= TAGW'(1);
      if (se < min_est_r) begin
        min_est_r <= se;
      end
    end
    if (cmd.scan_start) begin
      scx_r <= '0;
      scy_r <= '0;
      any_r <= 1'b0;
    end
    pv_r <= cmd.scan_issue;
    if (cmd.scan_issue) begin
      pvx_r <= scx_r;
      pvy_r <= scy_r;
      if ((DW'(scx_r) + DW'(1)) == w_r) begin
        scx_r <= '0;
        scy_r <= scy_r + 1'b1;
      end else begin
        scx_r <= scx_r + 1'b1;
      end
    end
    if (pv_r && better) begin
      any_r <= 1'b1;
      bx_r  <= pvx_r;
      by_r  <= pvy_r;
      bt_r  <= pt;
      be_r  <= pe;
      bg_r  <= tag_q;
    end
    if (cmd.exp_load) begin
      cblk_r  <= blk_q;
      cx_r    <= bx_r;
      cy_r    <= by_r;
      nb_r    <= '0;
      ncost_r <= CSTW'(bt_r - TW'(be_r)) + CSTW'(1);
    end
    if (cmd.nb_next) begin
      nb_r <= nb_r + 1'b1;
    end
    if (live && (nfresh || nopen)) begin
      tag_r <= tag_r + 1'b1;
    end
    if (live && nfresh && ne < min_est_r) begin
      min_est_r <= ne;
      clx_r     <= nx;
      cly_r     <= ny;
    end
    if (cmd.bt_init) begin
      wkx_r <= bx_r;
      wky_r <= by_r;
      n_r   <= NW'(1);
    end
    if (cmd.bt_cnt_step || cmd.bt_wr_step) begin
      wkx_r <= CW'(pred_q[XW-1:0]);
      wky_r <= CW'(pred_q[AW-1:XW]);
    end
    if (cmd.bt_cnt_step) begin
      n_r <= n_r + 1'b1;
    end
    if (cmd.bt_wr_init) begin
      wkx_r <= bx_r;
      wky_r <= by_r;
      k_r   <= n_r;
    end
    if (cmd.bt_wr_step) begin
      k_r <= k_r - 1'b1;
    end
  end

  always_comb begin
    sts             = '0;
    sts.req_type    = req_r.req_type;
    sts.leg_trivial = (lsx_r == lgx_r) && (lsy_r == lgy_r);
    sts.leg_outside = (DW'(lsx_r) >= w_r) || (DW'(lsy_r) >= h_r);
    sts.clr_last    = &clr_cnt_r;
    sts.scan_last   = ((DW'(scx_r) + DW'(1)) == w_r) && ((DW'(scy_r) + DW'(1)) == h_r);
    sts.any_open    = any_r;
    sts.goal_hit    = (b_lin == goal_lin_r);
    sts.nb_ok       = x_ok && y_ok && !(cblk_r && dyc == gaps_pkg::STEP_NEG);
    sts.nb_last     = (nb_r == 3'd7);
    sts.bt_at_start = (wkx_r == lsx_e) && (wky_r == lsy_e);
    sts.bt_k_last   = (k_r == NW'(1));
    sts.leg2_pend   = leg2p_r;
  end

  assign step_ok = 32'(req_r.step_index) < 32'(res_len_r);

  always_comb begin
    res             = '0;
    res.found       = res_found_r;
    res.path_length = gaps_pkg::LEN_W'(res_len_r);
    res.closest_x   = res_cx_r;
    res.closest_y   = res_cy_r;
    if (step_ok) begin
      res.step_x = CRD'(path_q[XW-1:0]);
      res.step_y = CRD'(path_q[AW-1:XW]);
    end
  end

  a_path_pos: assert property (@(posedge clk) disable iff (!rst_n)
    path_we |-> (pos < QW'(MAX_PATH)))
    else $error("path store write beyond capacity");

  a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.leg_fail |=> (!res_found_r && res_len_r == '0))
    else $error("failed leg left a path");

  a_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.leg_ok && !leg2p_r) |=> res_found_r)
    else $error("final leg success not reported");

endmodule

// File: sim/grid_astar_path_search_core_test.sv
// testbench of the grid path search block: queued requests, predicted results, random idling
`timescale 1ns / 100ps
module grid_astar_path_search_core_test;

  localparam int GW = 32;
  localparam int GH = 32;
  localparam int CELLS = GW * GH;
  localparam int PATH_MAX = 2048;
  localparam int CRD = gaps_pkg::COORD_W;
  localparam int IXW = gaps_pkg::IDX_W;
  localparam int LNW = gaps_pkg::LEN_W;
  localparam int CDW = gaps_pkg::CFG_DATA_W;
  localparam logic [gaps_pkg::REQ_W-1:0] REQ_NONE = 2'd3;
  localparam int SEARCH_BUDGET = 20000;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int REG_W = 6;
  localparam int REG_H = 5;
  localparam int MODE_FREE = 0;
  localparam int MODE_SEND_IDLE = 1;
  localparam int MODE_RECV_STALL = 2;
  localparam int MODE_BOTH = 3;

  typedef struct {
    gaps_pkg::in_req_t req;
    int                mode;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gaps_pkg::in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gaps_pkg::out_res_t out_res;
  logic cfg_wr_en = 1'b0;
  logic [gaps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gaps_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

  grid_astar_path_search_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pending_t request_q[$];
  gaps_pkg::out_res_t result_q[$];
  int errors = 0;
  int cur_mode = 0;
  longint cycles = 0;

  // predicted block state
  int grid_w = 32, grid_h = 32;
  bit blocked[CELLS];
  bit written[CELLS];
  bit hit_unwritten;
  bit open_f[CELLS];
  bit done_f[CELLS];
  int cost[CELLS];
  int pred[CELLS];
  int order_tag[CELLS];
  int path_cells[PATH_MAX];
  int leg_path[CELLS];
  int leg_len, leg_cx, leg_cy;
  int r_found, r_len, r_cx, r_cy;

  int ly_dx[8] = '{0, 0, -1, 1, -1, -1, 1, 1};
  int ly_dy[8] = '{-1, 1, 0, 0, -1, 1, 1, -1};
  int lx_dx[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  int lx_dy[8] = '{0, 0, -1, 1, -1, 1, 1, -1};

  function automatic int adiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int clamp_dim(int v, int lim);
    if (v < 1) return 1;
    return v > lim ? lim : v;
  endfunction

  function automatic int min_of(int a, int b);
    return a < b ? a : b;
  endfunction

  // map lookup that flags cells never written
  function automatic bit map_read(int i);
    if (!written[i]) hit_unwritten = 1;
    return blocked[i];
  endfunction

  // one A* leg; adds its cycle estimate to work
  function automatic bit run_leg(int sx, int sy, int gx, int gy, int w, int h,
                                 inout longint work);
    int tag, min_est, si, gi, c, n, bi, bt, be, bg, bx, by, ncost, nx, ny, ni, e, t, i;
    int ox[8], oy[8];
    bit found, any, cur_blk;
    tag = 0;
    found = 0;
    leg_len = 0;
    if (sx == gx && sy == gy) begin
      leg_cx = gx; leg_cy = gy;
      return 1;
    end
    leg_cx = sx; leg_cy = sy;
    if (sx >= w || sy >= h) return 0;
    work += 1100;
    for (i = 0; i < CELLS; i++) begin
      open_f[i] = 0; done_f[i] = 0;
    end
    min_est = w + h;
    si = sy * GW + sx;
    gi = gy * GW + gx;
    cost[si] = 0; pred[si] = si; order_tag[si] = tag++; open_f[si] = 1;
    if (adiff(sx, gx) + adiff(sy, gy) < min_est) min_est = adiff(sx, gx) + adiff(sy, gy);
    if (adiff(gy, sy) > adiff(gx, sx)) begin
      ox = ly_dx; oy = ly_dy;
    end else begin
      ox = lx_dx; oy = lx_dy;
    end
    forever begin
      any = 0; bi = 0; bt = 0; be = 0; bg = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          i = y * GW + x;
          if (open_f[i]) begin
            e = adiff(x, gx) + adiff(y, gy);
            t = e + cost[i];
            if (!any || t < bt || (t == bt && e < be) ||
                (t == bt && e == be && order_tag[i] < bg)) begin
              any = 1; bi = i; bt = t; be = e; bg = order_tag[i];
            end
          end
        end
      end
      work += w * h + 24;
      if (!any) break;
      open_f[bi] = 0;
      done_f[bi] = 1;
      if (bi == gi) begin
        found = 1;
        break;
      end
      bx = bi % GW;
      by = bi / GW;
      cur_blk = map_read(bi);
      ncost = cost[bi] + 1;
      for (n = 0; n < 8; n++) begin
        nx = bx + ox[n];
        ny = by + oy[n];
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        if (cur_blk && oy[n] == -1) continue;
        ni = ny * GW + nx;
        if (map_read(ni)) continue;
        if (!open_f[ni] && !done_f[ni]) begin
          e = adiff(nx, gx) + adiff(ny, gy);
          cost[ni] = ncost; pred[ni] = bi; order_tag[ni] = tag++; open_f[ni] = 1;
          if (e < min_est) begin
            min_est = e; leg_cx = nx; leg_cy = ny;
          end
        end else if (open_f[ni]) begin
          if (ncost < cost[ni]) begin
            cost[ni] = ncost; pred[ni] = bi;
          end
          order_tag[ni] = tag++;
        end
      end
    end
    if (!found) return 0;
    n = 1; c = gi;
    while (c != si && n <= CELLS) begin
      c = pred[c] % CELLS; n++;
    end
    if (n > CELLS) n = CELLS;
    leg_len = n;
    work += 6 * n;
    c = gi;
    while (n > 0) begin
      leg_path[n - 1] = c;
      c = pred[c] % CELLS;
      n--;
    end
    leg_cx = gx; leg_cy = gy;
    return 1;
  endfunction

  function automatic void append_leg(int from);
    for (int i = from; i < leg_len; i++)
      if (r_len < PATH_MAX) path_cells[r_len++] = leg_path[i];
  endfunction

  function automatic void search_predict(gaps_pkg::in_req_t r, inout longint work);
    int w, h, sx, sy, gx, gy, wx, wy;
    w = clamp_dim(grid_w, GW);
    h = clamp_dim(grid_h, GH);
    sx = int'(r.start_x); sy = int'(r.start_y);
    gx = int'(r.goal_x); gy = int'(r.goal_y);
    wx = int'(r.waypoint_x); wy = int'(r.waypoint_y);
    r_found = 0;
    r_len = 0;
    if (r.use_waypoint) begin
      if (!run_leg(sx, sy, wx, wy, w, h, work)) begin
        r_cx = leg_cx; r_cy = leg_cy;
        return;
      end
      append_leg(0);
      if (!run_leg(wx, wy, gx, gy, w, h, work)) begin
        r_len = 0;
        r_cx = leg_cx; r_cy = leg_cy;
        return;
      end
      append_leg(1);
    end else begin
      if (!run_leg(sx, sy, gx, gy, w, h, work)) begin
        r_cx = leg_cx; r_cy = leg_cy;
        return;
      end
      append_leg(0);
    end
    r_found = 1;
    r_cx = gx; r_cy = gy;
  endfunction

  function automatic gaps_pkg::out_res_t current_result(gaps_pkg::in_req_t r);
    gaps_pkg::out_res_t o;
    int c, sx, sy;
    o = '0;
    o.found = r_found[0];
    o.path_length = r_len[LNW-1:0];
    o.closest_x = r_cx[CRD-1:0];
    o.closest_y = r_cy[CRD-1:0];
    if (int'(r.step_index) < r_len) begin
      c = path_cells[r.step_index] % CELLS;
      sx = c % GW;
      sy = c / GW;
      o.step_x = sx[CRD-1:0];
      o.step_y = sy[CRD-1:0];
    end
    return o;
  endfunction

  // predicts and queues one request; a search over budget is undone unless forced,
  // and a search that would look at a never written map cell is always undone
  function automatic bit queue_request(gaps_pkg::in_req_t r, int mode, bit forced);
    longint work;
    int s_found, s_len, s_cx, s_cy, ci;
    int s_path[PATH_MAX];
    pending_t p;
    work = 0;
    if (r.req_type == gaps_pkg::REQ_MAP_WR) begin
      ci = int'(r.cell_y) * GW + int'(r.cell_x);
      blocked[ci] = r.cell_blocked;
      written[ci] = 1;
    end else if (r.req_type == gaps_pkg::REQ_SEARCH) begin
      s_found = r_found; s_len = r_len; s_cx = r_cx; s_cy = r_cy;
      s_path = path_cells;
      hit_unwritten = 0;
      search_predict(r, work);
      if (hit_unwritten || (!forced && work > SEARCH_BUDGET)) begin
        r_found = s_found; r_len = s_len; r_cx = s_cx; r_cy = s_cy;
        path_cells = s_path;
        return 0;
      end
    end
    p.req = r;
    p.mode = mode;
    request_q.insert(request_q.size(), p);
    result_q.insert(result_q.size(), current_result(r));
    return 1;
  endfunction

  function automatic gaps_pkg::in_req_t make_req(logic [gaps_pkg::REQ_W-1:0] kind);
    logic [63:0] raw;
    gaps_pkg::in_req_t r;
    raw = {$urandom, $urandom};
    r = raw[$bits(gaps_pkg::in_req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  function automatic void write_cell(int x, int y, bit b, int mode);
    gaps_pkg::in_req_t r;
    r = make_req(gaps_pkg::REQ_MAP_WR);
    r.cell_x = CRD'(x); r.cell_y = CRD'(y); r.cell_blocked = b;
    void'(queue_request(r, mode, 1));
  endfunction

  function automatic void read_step(int idx, int mode);
    gaps_pkg::in_req_t r;
    r = make_req(gaps_pkg::REQ_READ);
    r.step_index = IXW'(idx);
    void'(queue_request(r, mode, 1));
  endfunction

  function automatic void search(int sx, int sy, int gx, int gy, bit wp, int wx, int wy,
                                 int mode);
    gaps_pkg::in_req_t r;
    r = make_req(gaps_pkg::REQ_SEARCH);
    r.start_x = CRD'(sx); r.start_y = CRD'(sy); r.goal_x = CRD'(gx); r.goal_y = CRD'(gy);
    r.use_waypoint = wp; r.waypoint_x = CRD'(wx); r.waypoint_y = CRD'(wy);
    void'(queue_request(r, mode, 1));
  endfunction

  function automatic logic [CRD-1:0] pick_coord(int lim, int reg_lim);
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return CRD'($urandom_range(0, min_of(lim, reg_lim) - 1));
    if (k < 85) return CRD'($urandom_range(0, lim - 1));
    return CRD'($urandom_range(0, 31));
  endfunction

  function automatic void random_search(int mode);
    gaps_pkg::in_req_t r;
    int w, h;
    w = clamp_dim(grid_w, GW);
    h = clamp_dim(grid_h, GH);
    for (int k = 0; k < 10; k++) begin
      r = make_req(gaps_pkg::REQ_SEARCH);
      r.start_x = pick_coord(w, REG_W); r.start_y = pick_coord(h, REG_H);
      r.goal_x = pick_coord(w, REG_W); r.goal_y = pick_coord(h, REG_H);
      r.waypoint_x = pick_coord(w, REG_W); r.waypoint_y = pick_coord(h, REG_H);
      r.use_waypoint = $urandom_range(0, 2) == 0;
      if (queue_request(r, mode, 0)) return;
    end
    r.goal_x = r.start_x; r.goal_y = r.start_y; r.use_waypoint = 0;
    void'(queue_request(r, mode, 1));
  endfunction

  function automatic void random_items(int count);
    int n, mode, w, h, k;
    gaps_pkg::in_req_t r;
    n = 0;
    w = clamp_dim(grid_w, GW);
    h = clamp_dim(grid_h, GH);
    while (n < count) begin
      mode = (n / 6) % 4;
      k = $urandom_range(0, 99);
      if (k < 25) begin
        repeat ($urandom_range(1, 4)) begin
          write_cell($urandom_range(0, min_of(w, REG_W + 2) - 1),
                     $urandom_range(0, min_of(h, REG_H + 1) - 1),
                     $urandom_range(0, 99) < 30, mode);
          n++;
        end
      end else if (k < 60) begin
        random_search(mode);
        n++;
        repeat ($urandom_range(1, 3)) begin
          if (r_len > 0 && $urandom_range(0, 3) != 0) read_step($urandom_range(0, r_len), mode);
          else read_step($urandom_range(0, 2047), mode);
          n++;
        end
      end else if (k < 92) begin
        read_step($urandom_range(0, 2047), mode);
        n++;
      end else begin
        r = make_req(REQ_NONE);
        void'(queue_request(r, mode, 1));
        n++;
      end
    end
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_idle(int mode);
    case (mode)
      MODE_SEND_IDLE: return roll(55);
      MODE_BOTH: return roll(15);
      default: return 0;
    endcase
  endfunction

  function automatic bit receiver_stall(int mode);
    case (mode)
      MODE_RECV_STALL: return roll(55);
      MODE_BOTH: return roll(15);
      default: return 0;
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    pending_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_q.size() > 0 && !sender_idle(request_q[0].mode)) begin
        p = request_q.pop_front();
        cur_mode <= p.mode;
        in_req <= p.req;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    gaps_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = result_q.pop_front();
        if (out_res.found !== want.found) report("found", out_res.found, want.found);
        if (out_res.path_length !== want.path_length)
          report("path_length", out_res.path_length, want.path_length);
        if (out_res.closest_x !== want.closest_x)
          report("closest_x", out_res.closest_x, want.closest_x);
        if (out_res.closest_y !== want.closest_y)
          report("closest_y", out_res.closest_y, want.closest_y);
        if (out_res.step_x !== want.step_x) report("step_x", out_res.step_x, want.step_x);
        if (out_res.step_y !== want.step_y) report("step_y", out_res.step_y, want.step_y);
      end
    end
    out_stall <= rst_n ? receiver_stall(cur_mode) : 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL grid_astar_path_search_core");
      $finish;
    end
  end

  task automatic drain();
    wait (request_q.size() == 0 && result_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_dims(int w, int h);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= gaps_pkg::CFG_MAP_WIDTH;
    cfg_wr_data <= CDW'(w);
    @(posedge clk);
    cfg_index <= gaps_pkg::CFG_MAP_HEIGHT;
    cfg_wr_data <= CDW'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    grid_w = w;
    grid_h = h;
  endtask

  initial begin
    int dims[6][2] = '{'{6, 5}, '{0, 63}, '{63, 0}, '{4, 3}, '{5, 6}, '{32, 32}};
    r_found = 0; r_len = 0; r_cx = 0; r_cy = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    read_step(0, MODE_FREE);
    void'(queue_request(make_req(REQ_NONE), MODE_FREE, 1));
    search(5, 5, 5, 5, 0, 0, 0, MODE_FREE);
    // corner of the full grid at reset size
    write_cell(31, 31, 0, MODE_FREE);
    write_cell(30, 31, 0, MODE_FREE);
    write_cell(31, 30, 1, MODE_FREE);
    write_cell(30, 30, 1, MODE_FREE);
    search(31, 31, 30, 31, 0, 0, 0, MODE_FREE);
    read_step(0, MODE_FREE);
    read_step(1, MODE_FREE);
    read_step(2, MODE_FREE);
    write_cell(30, 31, 1, MODE_FREE);
    search(31, 31, 30, 31, 0, 0, 0, MODE_FREE);
    drain();
    set_dims(6, 5);
    for (int y = 0; y < REG_H; y++)
      for (int x = 0; x < REG_W; x++)
        write_cell(x, y, (x == 2) && (y == 1 || y == 2), MODE_FREE);
    search(0, 0, 5, 4, 0, 0, 0, MODE_FREE);
    read_step(1, MODE_FREE);
    // blocked start: no moves upward from it
    search(2, 2, 2, 0, 0, 0, 0, MODE_FREE);
    // blocked goal
    search(0, 4, 2, 1, 0, 0, 0, MODE_FREE);
    search(3, 3, 3, 3, 0, 0, 0, MODE_FREE);
    search(7, 1, 0, 0, 0, 0, 0, MODE_FREE);
    search(0, 0, 9, 2, 0, 0, 0, MODE_FREE);
    search(0, 0, 5, 0, 1, 3, 4, MODE_FREE);
    read_step(2, MODE_FREE);
    read_step(2047, MODE_FREE);
    search(0, 0, 5, 0, 1, 2, 2, MODE_FREE);
    search(0, 0, 2, 1, 1, 5, 4, MODE_FREE);
    search(0, 0, 0, 0, 1, 4, 3, MODE_FREE);
    search(1, 1, 4, 4, 1, 1, 1, MODE_FREE);
    void'(queue_request(make_req(REQ_NONE), MODE_FREE, 1));
    read_step(0, MODE_FREE);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_dims(dims[ph][0], dims[ph][1]);
      random_items(14);
      drain();
    end
    if (errors == 0) begin
      $display("PASS grid_astar_path_search_core");
    end else begin
      $display("FAIL grid_astar_path_search_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gaps_pkg.sv
hdl/gaps_ctrl.sv
hdl/gaps_dpath.sv
hdl/grid_astar_path_search_core.sv
sim/grid_astar_path_search_core_test.sv
